>>> sv/mctp_pkg.sv
package mctp_pkg;

   localparam int OFFSET_BITS = 21;
   // next tag position can run past the block by one tag and its data
   localparam int NTA_BITS    = OFFSET_BITS + 1;
   localparam int CMP_BITS    = OFFSET_BITS + 2;

   localparam logic [31:0]            ALL_ONES    = 32'hFFFF_FFFF;
   localparam logic [31:0]            CRC_POLY    = 32'hEDB8_8320;
   localparam logic [9:0]             SIZE_NONE   = 10'h3FF;
   localparam logic [10:0]            TYPE_FCRC   = 11'h5FF;
   localparam logic [2:0]             TYPE_CRC_HI = 3'd5;
   localparam logic [OFFSET_BITS-1:0] BLK_LEN_RST = OFFSET_BITS'(4096);

   typedef enum logic [2:0] {
      KIND_REV      = 3'd0,
      KIND_TAG      = 3'd1,
      KIND_DATA     = 3'd2,
      KIND_COMMIT   = 3'd3,
      KIND_MISMATCH = 3'd4,
      KIND_INVALID  = 3'd5
   } kind_type;

   typedef enum logic [5:0] {
      PH_REV  = 6'b000001,
      PH_SKIP = 6'b000010,
      PH_TAG  = 6'b000100,
      PH_DATA = 6'b001000,
      PH_CRCW = 6'b010000,
      PH_DONE = 6'b100000
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       block_start;
   } req_type;

   typedef struct packed {
      kind_type    kind;
      logic [10:0] tag_code;
      logic [9:0]  tag_id;
      logic [9:0]  tag_len;
      logic [7:0]  payload_byte;
      logic [31:0] word_value;
      logic [19:0] byte_offset;
   } rsp_type;

   // reflected crc-32, one byte
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   function automatic logic [31:0] swap32(input logic [31:0] v);
      return {v[7:0], v[15:8], v[23:16], v[31:24]};
   endfunction

endpackage

>>> sv/metadata_commit_tag_parser.sv
// channel   | ports                              | direction | moves
// ----------+------------------------------------+-----------+---------------------------
// request   | req_valid, req_stall, req_data     | in        | one block byte per request
// result    | rsp_valid, rsp_stall, rsp_data     | out       | zero or one result per byte
// config    | csr_wr_en, csr_wr_data             | in        | block length, no read-back
//
// one request per cycle while results are not stalled; a byte is held in the input register,
// and its result is then registered in the result register, which drives rsp_valid
// the parse step is one pass of crc byte update, tag xor and offset compares
// reset is synchronous and active high; the block length returns to 4096
// a stalled result holds the input register, which then stalls requests
module metadata_commit_tag_parser (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  mctp_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output mctp_pkg::rsp_type                   rsp_data,
   input  logic                                csr_wr_en,
   input  logic [mctp_pkg::OFFSET_BITS-1:0]    csr_wr_data
);
   import mctp_pkg::*;

   // input register
   logic    in_vld_ff, in_vld_in;
   req_type in_ff;

   // result register
   logic    rsp_vld_ff, rsp_vld_in;
   rsp_type rsp_ff;

   // configuration
   logic [OFFSET_BITS-1:0] blk_len_ff;

   // parse state
   phase_type              phase_ff, phase_in;
   logic [OFFSET_BITS-1:0] pos_ff, pos_in;
   logic [NTA_BITS-1:0]    nta_ff, nta_in;
   logic [31:0]            prev_ff, prev_in;
   logic [31:0]            crc_ff, crc_in;
   logic [31:0]            ws_ff, ws_in;
   logic [31:0]            cur_tag_ff, cur_tag_in;
   logic [9:0]             left_ff, left_in;

   // state after an optional block_start clear
   phase_type              cur_phase;
   logic [OFFSET_BITS-1:0] cur_pos;
   logic [NTA_BITS-1:0]    cur_nta;
   logic [31:0]            cur_prev, cur_crc, cur_ws, cur_tag;
   logic [9:0]             cur_left;

   logic    req_accept, proc_go;
   logic    res_vld;
   rsp_type res;

   // parse step helpers
   logic [31:0]         ws_next, crc_fed, tag_dec, stored_crc;
   logic [CMP_BITS-1:0] pos_p1, adv_nxt;
   logic                adv_req;
   logic [9:0]          dlen, left_dec;
   logic [10:0]         dec_type, cur_type;

   function automatic rsp_type make_rsp(input kind_type k, input logic [31:0] tag,
                                        input logic [7:0] pay, input logic [31:0] word,
                                        input logic [OFFSET_BITS-1:0] pos);
      rsp_type r;
      r.kind         = k;
      r.tag_code     = tag[30:20];
      r.tag_id       = tag[19:10];
      r.tag_len      = tag[9:0];
      r.payload_byte = pay;
      r.word_value   = word;
      r.byte_offset  = pos[19:0];
      return r;
   endfunction

   // handshake: the parse step runs when the input register holds a byte and
   // the result register is free or being drained
   assign proc_go    = in_vld_ff && (!rsp_vld_ff || !rsp_stall);
   assign req_stall  = in_vld_ff && !proc_go;
   assign req_accept = req_valid && !req_stall;
   assign in_vld_in  = req_accept || (in_vld_ff && !proc_go);
   assign rsp_vld_in = proc_go ? res_vld : (rsp_vld_ff && rsp_stall);
   assign rsp_valid  = rsp_vld_ff;
   assign rsp_data   = rsp_ff;

   // block_start clears the parse state before this byte is taken
   always_comb begin
      if (in_ff.block_start) begin
         cur_phase = PH_REV;
         cur_pos   = '0;
         cur_nta   = NTA_BITS'(4);
         cur_prev  = ALL_ONES;
         cur_crc   = ALL_ONES;
         cur_ws    = '0;
         cur_tag   = '0;
         cur_left  = '0;
      end else begin
         cur_phase = phase_ff;
         cur_pos   = pos_ff;
         cur_nta   = nta_ff;
         cur_prev  = prev_ff;
         cur_crc   = crc_ff;
         cur_ws    = ws_ff;
         cur_tag   = cur_tag_ff;
         cur_left  = left_ff;
      end
   end

   assign ws_next    = {cur_ws[23:0], in_ff.data_byte};
   assign crc_fed    = crc_byte(cur_crc, in_ff.data_byte);
   assign tag_dec    = ws_next ^ cur_prev;
   assign stored_crc = swap32(ws_next);
   assign dec_type   = tag_dec[30:20];
   assign cur_type   = cur_tag[30:20];
   assign dlen       = (tag_dec[9:0] == SIZE_NONE) ? 10'd0 : tag_dec[9:0];
   assign left_dec   = cur_left - 10'd1;
   assign pos_p1     = {2'b00, cur_pos} + CMP_BITS'(1);

   always_comb begin
      phase_in   = phase_ff;
      pos_in     = pos_ff;
      nta_in     = nta_ff;
      prev_in    = prev_ff;
      crc_in     = crc_ff;
      ws_in      = ws_ff;
      cur_tag_in = cur_tag_ff;
      left_in    = left_ff;
      res_vld    = 1'b0;
      res        = make_rsp(KIND_REV, '0, '0, '0, cur_pos);
      adv_req    = 1'b0;
      adv_nxt    = '0;
      if (proc_go) begin
         phase_in   = cur_phase;
         pos_in     = cur_pos;
         nta_in     = cur_nta;
         prev_in    = cur_prev;
         crc_in     = cur_crc;
         ws_in      = cur_ws;
         cur_tag_in = cur_tag;
         left_in    = cur_left;
         if (cur_phase != PH_DONE) begin
            if (cur_pos >= blk_len_ff) begin
               phase_in = PH_DONE;
            end else begin
               ws_in  = ws_next;
               pos_in = cur_pos + OFFSET_BITS'(1);
               unique case (cur_phase)
                  PH_REV: begin
                     crc_in = crc_fed;
                     if (cur_pos >= OFFSET_BITS'(3)) begin
                        res_vld = 1'b1;
                        res     = make_rsp(KIND_REV, '0, '0, stored_crc, cur_pos);
                        adv_req = 1'b1;
                        adv_nxt = CMP_BITS'(4);
                     end
                  end
                  PH_SKIP: begin
                     if ({1'b0, cur_nta} <= pos_p1) begin
                        phase_in = PH_TAG;
                     end
                  end
                  PH_TAG: begin
                     crc_in = crc_fed;
                     if ({2'b00, cur_pos} >= {1'b0, cur_nta} + CMP_BITS'(3)) begin
                        cur_tag_in = tag_dec;
                        res_vld    = 1'b1;
                        if (tag_dec[31]) begin
                           res      = make_rsp(KIND_INVALID, tag_dec, '0, tag_dec, cur_pos);
                           phase_in = PH_DONE;
                        end else if (dec_type[10:8] == TYPE_CRC_HI && dec_type != TYPE_FCRC)
                        begin
                           // commit crc: at least the four stored crc bytes are skipped
                           res      = make_rsp(KIND_TAG, tag_dec, '0, tag_dec, cur_pos);
                           nta_in   = cur_nta + NTA_BITS'(4)
                                    + ((dlen < 10'd4) ? NTA_BITS'(4) : NTA_BITS'(dlen));
                           left_in  = 10'd4;
                           phase_in = PH_CRCW;
                        end else begin
                           res     = make_rsp(KIND_TAG, tag_dec, '0, tag_dec, cur_pos);
                           prev_in = tag_dec;
                           if (dlen != 10'd0) begin
                              nta_in   = cur_nta + NTA_BITS'(4) + NTA_BITS'(dlen);
                              left_in  = dlen;
                              phase_in = PH_DATA;
                           end else begin
                              adv_req = 1'b1;
                              adv_nxt = {1'b0, cur_nta} + CMP_BITS'(4);
                           end
                        end
                     end
                  end
                  PH_DATA: begin
                     crc_in  = crc_fed;
                     res_vld = 1'b1;
                     res     = make_rsp(KIND_DATA, cur_tag, in_ff.data_byte, cur_tag, cur_pos);
                     left_in = left_dec;
                     if (left_dec == 10'd0) begin
                        adv_req = 1'b1;
                        adv_nxt = {1'b0, cur_nta};
                     end
                  end
                  PH_CRCW: begin
                     left_in = left_dec;
                     if (left_dec == 10'd0) begin
                        res_vld = 1'b1;
                        if (stored_crc != cur_crc) begin
                           res      = make_rsp(KIND_MISMATCH, cur_tag, '0, cur_crc, cur_pos);
                           phase_in = PH_DONE;
                        end else begin
                           // low type bit flips the valid sense of the next tag chain
                           res     = make_rsp(KIND_COMMIT, cur_tag, '0, cur_crc, cur_pos);
                           prev_in = cur_tag ^ {cur_type[0], 31'd0};
                           crc_in  = ALL_ONES;
                           adv_req = 1'b1;
                           adv_nxt = {1'b0, cur_nta};
                        end
                     end
                  end
                  default: begin
                     phase_in = PH_DONE;
                  end
               endcase
               // pick the next phase once the revision word, a tag, its data or a commit is finished
               if (adv_req) begin
                  if (adv_nxt + CMP_BITS'(4) > {2'b00, blk_len_ff}) begin
                     phase_in = PH_DONE;
                  end else begin
                     nta_in   = {1'b0, adv_nxt[OFFSET_BITS-1:0]};
                     phase_in = ({2'b00, adv_nxt[OFFSET_BITS-1:0]} <= pos_p1) ? PH_TAG
                                                                             : PH_SKIP;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         blk_len_ff <= BLK_LEN_RST;
         phase_ff   <= PH_REV;
         pos_ff     <= '0;
         nta_ff     <= NTA_BITS'(4);
         prev_ff    <= ALL_ONES;
         crc_ff     <= ALL_ONES;
         ws_ff      <= '0;
         cur_tag_ff <= '0;
         left_ff    <= '0;
      end else begin
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         if (csr_wr_en) begin
            blk_len_ff <= csr_wr_data;
         end
         phase_ff   <= phase_in;
         pos_ff     <= pos_in;
         nta_ff     <= nta_in;
         prev_ff    <= prev_in;
         crc_ff     <= crc_in;
         ws_ff      <= ws_in;
         cur_tag_ff <= cur_tag_in;
         left_ff    <= left_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_ff <= req_data;
      end
      if (proc_go && res_vld) begin
         rsp_ff <= res;
      end
   end

   // a stall toward the requester only comes from a full input register
   a_stall_src: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_vld_ff)
      else $error("request stall without a held request");

   // a crc mismatch or an invalid tag stops the block
   a_stop: assert property (@(posedge clock) disable iff (reset)
      (proc_go && res_vld && (res.kind == KIND_MISMATCH || res.kind == KIND_INVALID))
      |=> phase_ff == PH_DONE)
      else $error("parser did not stop after a failed commit");

   // data phase always has bytes left to take
   a_data_left: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA |-> left_ff != 10'd0)
      else $error("data phase with no bytes left");

   // stored crc countdown stays within its four bytes
   a_crc_left: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_CRCW |-> (left_ff != 10'd0 && left_ff <= 10'd4))
      else $error("stored crc countdown out of range");

endmodule
